FILE: rtl/core/eptt_pkg.sv
// eptt_pkg: shared constants, register map and types for the elapsed time
// period trigger; no dependencies
package eptt_pkg;

    localparam int EPTT_SEC_BITS = 32;

    localparam logic [30:0] NS_PER_S = 31'd1000000000;
    localparam logic [29:0] NS_MAX = 30'd999999999;

    localparam logic [7:0] PERIOD_SEC_RESET = 8'd1;
    localparam logic [29:0] PERIOD_NSEC_RESET = 30'd0;

    typedef enum logic [0:0] {
        REG_PERIOD_SEC  = 1'b0,
        REG_PERIOD_NSEC = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic        fired;
        logic [7:0]  acc_sec;
        logic [29:0] acc_nsec;
    } calc_out_t;

endpackage

FILE: rtl/core/eptt_calc.sv
// eptt_calc: one tick of elapsed time arithmetic, stamp difference with
// nanosecond borrow, running sum with carry, compare against the period
// depends on eptt_pkg
module eptt_calc #(
    parameter int SEC_BITS = eptt_pkg::EPTT_SEC_BITS
) (
    input  logic [SEC_BITS-1:0] now_sec,
    input  logic [29:0]         now_nsec,
    input  logic [SEC_BITS-1:0] last_sec,
    input  logic [29:0]         last_nsec,
    input  logic [7:0]          acc_sec,
    input  logic [29:0]         acc_nsec,
    input  logic [7:0]          per_sec,
    input  logic [29:0]         per_nsec,
    output eptt_pkg::calc_out_t res
);

    localparam int SW = SEC_BITS + 1;

    logic                borrow;
    logic [30:0]         dn_wide;
    logic [29:0]         dn;
    logic [SEC_BITS-1:0] ds;
    logic [30:0]         sn_wide;
    logic                carry;
    logic [29:0]         sn;
    logic [SW-1:0]       ss;
    logic                fire;

    always_comb
    begin
        borrow = now_nsec < last_nsec;
        if (borrow)
        begin
            dn_wide = 31'(now_nsec) + eptt_pkg::NS_PER_S - 31'(last_nsec);
        end
        else
        begin
            dn_wide = 31'(now_nsec) - 31'(last_nsec);
        end
        dn = dn_wide[29:0];
        ds = now_sec - last_sec - SEC_BITS'(borrow);

        sn_wide = 31'(acc_nsec) + 31'(dn);
        carry = sn_wide >= eptt_pkg::NS_PER_S;
        if (carry)
        begin
            sn = 30'(sn_wide - eptt_pkg::NS_PER_S);
        end
        else
        begin
            sn = sn_wide[29:0];
        end
        ss = SW'(ds) + SW'(acc_sec) + SW'(carry);

        fire = (ss > SW'(per_sec)) || ((ss == SW'(per_sec)) && (sn >= per_nsec));

        res.fired = fire;
        res.acc_sec = fire ? 8'd0 : ss[7:0];
        res.acc_nsec = fire ? 30'd0 : sn;
    end

endmodule

FILE: rtl/core/elapsed_time_period_trigger.sv
// elapsed_time_period_trigger: top level, input register, state, result
// register and configuration port; depends on eptt_pkg and eptt_calc
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while out_ready is high; eptt_calc is combinational
// an input register and a result register part the two channels
// reset: asynchronous, active low; clears stamp, sum and valids,
// period returns to one second
module elapsed_time_period_trigger #(
    parameter int SEC_BITS = eptt_pkg::EPTT_SEC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_sec,
    input  logic [29:0] now_nsec,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        fired,
    output logic [31:0] stamp_sec,
    output logic [29:0] stamp_nsec,
    output logic [7:0]  accum_sec,
    output logic [29:0] accum_nsec
);

    logic [7:0]          period_sec_reg;
    logic [29:0]         period_nsec_reg;
    logic [29:0]         per_nsec_clamp_reg;
    eptt_pkg::reg_index_t reg_index;
    logic                cfg_write;

    logic                in_full_reg;
    logic [SEC_BITS-1:0] now_sec_reg;
    logic [29:0]         now_nsec_reg;
    logic [29:0]         now_nsec_clamp;

    logic [SEC_BITS-1:0] last_sec_reg;
    logic [29:0]         last_nsec_reg;
    logic [7:0]          acc_sec_reg;
    logic [29:0]         acc_nsec_reg;

    logic                out_valid_reg;
    logic                fired_reg;
    logic [31:0]         stamp_sec_reg;
    logic [29:0]         stamp_nsec_reg;
    logic [7:0]          accum_sec_reg;
    logic [29:0]         accum_nsec_reg;

    logic                advance;
    logic                in_take;
    eptt_pkg::calc_out_t calc_res;

    // configuration port
    assign pready = 1'b1;
    assign reg_index = eptt_pkg::reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_sec_reg <= eptt_pkg::PERIOD_SEC_RESET;
            period_nsec_reg <= eptt_pkg::PERIOD_NSEC_RESET;
            per_nsec_clamp_reg <= eptt_pkg::PERIOD_NSEC_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                eptt_pkg::REG_PERIOD_SEC:
                begin
                    period_sec_reg <= pwdata[7:0];
                end
                eptt_pkg::REG_PERIOD_NSEC:
                begin
                    period_nsec_reg <= pwdata[29:0];
                    per_nsec_clamp_reg <= (pwdata[29:0] > eptt_pkg::NS_MAX) ?
                        eptt_pkg::NS_MAX : pwdata[29:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            eptt_pkg::REG_PERIOD_SEC:  prdata = 32'(period_sec_reg);
            eptt_pkg::REG_PERIOD_NSEC: prdata = 32'(period_nsec_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // handshake
    assign advance = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;
    assign in_take = in_valid && in_ready;
    assign now_nsec_clamp = (now_nsec > eptt_pkg::NS_MAX) ? eptt_pkg::NS_MAX : now_nsec;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_sec_reg <= SEC_BITS'(now_sec);
            now_nsec_reg <= now_nsec_clamp;
        end
    end

    eptt_calc #(
        .SEC_BITS (SEC_BITS)
    ) u_calc (
        .now_sec   (now_sec_reg),
        .now_nsec  (now_nsec_reg),
        .last_sec  (last_sec_reg),
        .last_nsec (last_nsec_reg),
        .acc_sec   (acc_sec_reg),
        .acc_nsec  (acc_nsec_reg),
        .per_sec   (period_sec_reg),
        .per_nsec  (per_nsec_clamp_reg),
        .res       (calc_res)
    );

    // stored stamp and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sec_reg <= '0;
            last_nsec_reg <= '0;
            acc_sec_reg <= '0;
            acc_nsec_reg <= '0;
        end
        else if (advance)
        begin
            last_sec_reg <= now_sec_reg;
            last_nsec_reg <= now_nsec_reg;
            acc_sec_reg <= calc_res.acc_sec;
            acc_nsec_reg <= calc_res.acc_nsec;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg <= calc_res.fired;
            stamp_sec_reg <= 32'(now_sec_reg);
            stamp_nsec_reg <= now_nsec_reg;
            accum_sec_reg <= calc_res.acc_sec;
            accum_nsec_reg <= calc_res.acc_nsec;
        end
    end

    assign out_valid = out_valid_reg;
    assign fired = fired_reg;
    assign stamp_sec = stamp_sec_reg;
    assign stamp_nsec = stamp_nsec_reg;
    assign accum_sec = accum_sec_reg;
    assign accum_nsec = accum_nsec_reg;

endmodule

FILE: rtl/core/eptt_check.sv
// eptt_check: port-level checks for elapsed_time_period_trigger, bound to
// the top level; depends on eptt_pkg
module eptt_check (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        fired,
    input logic [31:0] stamp_sec,
    input logic [29:0] stamp_nsec,
    input logic [7:0]  accum_sec,
    input logic [29:0] accum_nsec
);

    // a fired item clears the sum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> (accum_sec == 8'd0) && (accum_nsec == 30'd0))
        else $error("fired item with nonzero sum");

    // nanosecond fields stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accum_nsec <= eptt_pkg::NS_MAX) && (stamp_nsec <= eptt_pkg::NS_MAX))
        else $error("nanosecond field out of range");

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired) && $stable(stamp_sec)
            && $stable(stamp_nsec) && $stable(accum_sec) && $stable(accum_nsec))
        else $error("stalled item changed");

endmodule

bind elapsed_time_period_trigger eptt_check u_eptt_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired      (fired),
    .stamp_sec  (stamp_sec),
    .stamp_nsec (stamp_nsec),
    .accum_sec  (accum_sec),
    .accum_nsec (accum_nsec)
);
